>>> sv/swpf_pkg.sv
// shared types, constants and the byte-wide crc-16 update for the servo write framer
// no dependencies
package swpf_pkg;

  localparam int MAX_DATA_BYTES = 4;
  localparam int CNT_W = 3;
  localparam int POS_W = 4;

  localparam logic [15:0] CRC_POLY = 16'h8005;

  localparam logic [7:0] HDR_BYTE0 = 8'hFF;
  localparam logic [7:0] HDR_BYTE2 = 8'hFD;
  localparam logic [7:0] RSRV_BYTE = 8'h00;
  localparam logic [7:0] INST_WRITE = 8'h03;
  localparam logic [7:0] LEN_HI_BYTE = 8'h00;
  localparam logic [7:0] LEN_OVERHEAD = 8'd5;

  // byte positions of the fixed part of the packet
  localparam logic [POS_W-1:0] POS_HDR0 = 4'd0;
  localparam logic [POS_W-1:0] POS_HDR1 = 4'd1;
  localparam logic [POS_W-1:0] POS_HDR2 = 4'd2;
  localparam logic [POS_W-1:0] POS_RSRV = 4'd3;
  localparam logic [POS_W-1:0] POS_ID = 4'd4;
  localparam logic [POS_W-1:0] POS_LEN_LO = 4'd5;
  localparam logic [POS_W-1:0] POS_LEN_HI = 4'd6;
  localparam logic [POS_W-1:0] POS_INST = 4'd7;
  // crc low byte sits at count + this offset, high byte one later
  localparam logic [POS_W-1:0] POS_CRC_OFS = 4'd10;

  typedef struct packed {
    logic [15:0]      reg_address;
    logic [31:0]      write_value;
    logic [CNT_W-1:0] byte_count;
  } swpf_in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } swpf_out_t;

  typedef struct packed {
    logic clear;
    logic update;
  } swpf_crc_ctl_t;

  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> sv/swpf_crc.sv
// running crc-16 (poly 8005, non-reflected, init 0), one byte per cycle while update is set
// depends on swpf_pkg
module swpf_crc (
  input  logic                   clk,
  input  logic                   rst_n,
  input  swpf_pkg::swpf_crc_ctl_t ctl,
  input  logic [7:0]             data,
  output logic [15:0]            crc
);

  logic [15:0] crc_r;
  logic [15:0] crc_nxt;

  always_comb begin
    crc_nxt = crc_r;
    if (ctl.clear) begin
      crc_nxt = 16'h0000;
    end else if (ctl.update) begin
      crc_nxt = swpf_pkg::crc_add(crc_r, data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= 16'h0000;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  assign crc = crc_r;

endmodule

>>> sv/servo_write_packet_framer_core.sv
// servo protocol 2.0 write packet framer: one request in, 12 + count bytes out
// depends on swpf_pkg and swpf_crc
// the first byte of an accepted item is loaded when the output register is free
// throughput: one byte per cycle while out_ready is high; address and value bytes
//   leave a 48-bit shift register a byte a cycle; in_ready low until last byte loads
// reset (synchronous, rst_n low): idle, output empty, crc cleared, servo id = 1
module servo_write_packet_framer_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  swpf_pkg::swpf_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output swpf_pkg::swpf_out_t out_data,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data
);

  localparam int PW = swpf_pkg::POS_W;
  localparam int CW = swpf_pkg::CNT_W;

  logic [7:0]   id_r;
  logic         busy_r, busy_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [47:0]  sh_r, sh_nxt;
  logic         oval_r, oval_nxt;
  swpf_pkg::swpf_out_t odat_r, odat_nxt;

  logic         accept;
  logic         load;
  logic [CW-1:0] cnt_sat;
  logic [PW-1:0] crc_lo_pos;
  logic [PW-1:0] crc_hi_pos;
  logic [7:0]   byte_sel;
  logic         shift_sel;
  logic         crc_upd;
  logic         last_sel;
  logic [15:0]  crc;
  swpf_pkg::swpf_crc_ctl_t crc_ctl;

  assign in_ready = !busy_r;
  assign accept = in_valid && in_ready;
  assign load = busy_r && (!oval_r || out_ready);

  always_comb begin
    cnt_sat = in_data.byte_count;
    if (in_data.byte_count > CW'(swpf_pkg::MAX_DATA_BYTES)) begin
      cnt_sat = CW'(swpf_pkg::MAX_DATA_BYTES);
    end else if (in_data.byte_count == '0) begin
      cnt_sat = CW'(1);
    end
  end

  assign crc_lo_pos = PW'(cnt_r) + swpf_pkg::POS_CRC_OFS;
  assign crc_hi_pos = crc_lo_pos + PW'(1);

  // packet byte for the current position
  always_comb begin
    byte_sel = sh_r[7:0];
    shift_sel = 1'b0;
    crc_upd = 1'b1;
    last_sel = 1'b0;
    unique case (pos_r) inside
      swpf_pkg::POS_HDR0, swpf_pkg::POS_HDR1: byte_sel = swpf_pkg::HDR_BYTE0;
      swpf_pkg::POS_HDR2:   byte_sel = swpf_pkg::HDR_BYTE2;
      swpf_pkg::POS_RSRV:   byte_sel = swpf_pkg::RSRV_BYTE;
      swpf_pkg::POS_ID:     byte_sel = id_r;
      swpf_pkg::POS_LEN_LO: byte_sel = 8'(cnt_r) + swpf_pkg::LEN_OVERHEAD;
      swpf_pkg::POS_LEN_HI: byte_sel = swpf_pkg::LEN_HI_BYTE;
      swpf_pkg::POS_INST:   byte_sel = swpf_pkg::INST_WRITE;
      default: begin
        if (pos_r == crc_lo_pos) begin
          byte_sel = crc[7:0];
          crc_upd = 1'b0;
        end else if (pos_r == crc_hi_pos) begin
          byte_sel = crc[15:8];
          crc_upd = 1'b0;
          last_sel = 1'b1;
        end else begin
          // address then value, low byte first
          shift_sel = 1'b1;
        end
      end
    endcase
  end

  assign crc_ctl.clear = accept;
  assign crc_ctl.update = load && crc_upd;

  swpf_crc u_crc (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (crc_ctl),
    .data (byte_sel),
    .crc  (crc)
  );

  always_comb begin
    busy_nxt = busy_r;
    pos_nxt = pos_r;
    cnt_nxt = cnt_r;
    sh_nxt = sh_r;
    oval_nxt = oval_r;
    odat_nxt = odat_r;
    if (oval_r && out_ready) begin
      oval_nxt = 1'b0;
    end
    if (accept) begin
      busy_nxt = 1'b1;
      pos_nxt = '0;
      cnt_nxt = cnt_sat;
      sh_nxt = {in_data.write_value, in_data.reg_address};
    end else if (load) begin
      oval_nxt = 1'b1;
      odat_nxt.tx_byte = byte_sel;
      odat_nxt.last_byte = last_sel;
      pos_nxt = pos_r + PW'(1);
      if (shift_sel) begin
        sh_nxt = {8'h00, sh_r[47:8]};
      end
      if (last_sel) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r <= 8'd1;
      busy_r <= 1'b0;
      pos_r <= '0;
      cnt_r <= CW'(1);
      oval_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        id_r <= cfg_wr_data;
      end
      busy_r <= busy_nxt;
      pos_r <= pos_nxt;
      cnt_r <= cnt_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
    odat_r <= odat_nxt;
  end

  assign out_valid = oval_r;
  assign out_data = odat_r;

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// testbench for servo_write_packet_framer_core: drives write requests and checks every packet byte
// depends on swpf_pkg and the framer core; predicts each packet with its own crc-16 (0x8005)
module testbench;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_PRINTS = 40;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  swpf_pkg::swpf_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  swpf_pkg::swpf_out_t out_data;
  logic      cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;

  swpf_pkg::swpf_in_t  request_q[$];
  swpf_pkg::swpf_out_t packet_byte_q[$];
  logic [7:0] servo_id_now = 8'd1;
  logic      in_taken = 1'b0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_seq = 0;
  int        hold_seen = 0;
  int        hold_left = 0;
  int        idle_cycles = 0;
  int        mismatch_count = 0;

  servo_write_packet_framer_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // msb-first bitwise form of the packet crc
  function automatic logic [15:0] crc8005_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = c << 1;
      if (fb) begin
        c = c ^ swpf_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

  task automatic push_packet_byte(input logic [7:0] b, input logic last, inout logic [15:0] crc);
    swpf_pkg::swpf_out_t o;
    o.tx_byte = b;
    o.last_byte = last;
    packet_byte_q.push_back(o);
    crc = crc8005_byte(crc, b);
  endtask

  task automatic frame_write_packet(input swpf_pkg::swpf_in_t req);
    logic [15:0] crc;
    logic [15:0] crc_final;
    int          cnt;
    crc = 16'h0000;
    cnt = req.byte_count;
    // oversize counts saturate, zero is raised to one
    if (cnt > swpf_pkg::MAX_DATA_BYTES) begin
      cnt = swpf_pkg::MAX_DATA_BYTES;
    end
    if (cnt < 1) begin
      cnt = 1;
    end
    push_packet_byte(swpf_pkg::HDR_BYTE0, 1'b0, crc);
    push_packet_byte(swpf_pkg::HDR_BYTE0, 1'b0, crc);
    push_packet_byte(swpf_pkg::HDR_BYTE2, 1'b0, crc);
    push_packet_byte(swpf_pkg::RSRV_BYTE, 1'b0, crc);
    push_packet_byte(servo_id_now, 1'b0, crc);
    push_packet_byte(8'(cnt) + swpf_pkg::LEN_OVERHEAD, 1'b0, crc);
    push_packet_byte(swpf_pkg::LEN_HI_BYTE, 1'b0, crc);
    push_packet_byte(swpf_pkg::INST_WRITE, 1'b0, crc);
    push_packet_byte(req.reg_address[7:0], 1'b0, crc);
    push_packet_byte(req.reg_address[15:8], 1'b0, crc);
    for (int i = 0; i < cnt; i++) begin
      push_packet_byte(req.write_value[8*i +: 8], 1'b0, crc);
    end
    crc_final = crc;
    push_packet_byte(crc_final[7:0], 1'b0, crc);
    push_packet_byte(crc_final[15:8], 1'b1, crc);
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  function automatic swpf_pkg::swpf_in_t rand_request();
    swpf_pkg::swpf_in_t r;
    r.reg_address = 16'($urandom);
    r.write_value = $urandom;
    if ($urandom_range(9) < 8) begin
      r.byte_count = 3'($urandom_range(4, 1));
    end else begin
      r.byte_count = 3'($urandom_range(7));
    end
    return r;
  endfunction

  task automatic queue_request(input logic [15:0] addr, input logic [31:0] val,
                               input logic [2:0] cnt);
    swpf_pkg::swpf_in_t r;
    r.reg_address = addr;
    r.write_value = val;
    r.byte_count = cnt;
    request_q.push_back(r);
  endtask

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) begin
      request_q.push_back(rand_request());
    end
  endtask

  // returns at a falling edge with nothing pending and nothing in flight
  task automatic wait_drained();
    @(posedge clk);
    while (request_q.size() != 0 || in_valid || packet_byte_q.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic write_servo_id(input logic [7:0] id);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= id;
    servo_id_now = id;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // request driver
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (rst_n && request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= request_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // byte receiver, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    swpf_pkg::swpf_out_t want;
    in_taken = rst_n && in_valid && in_ready;
    if (in_taken) begin
      frame_write_packet(in_data);
    end
    if (rst_n && out_valid && out_ready) begin
      if (packet_byte_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b",
                                  out_data.tx_byte, out_data.last_byte));
      end else begin
        want = packet_byte_q.pop_front();
        if (out_data.tx_byte !== want.tx_byte) begin
          report_mismatch($sformatf("tx_byte %02h, predicted %02h",
                                    out_data.tx_byte, want.tx_byte));
        end
        if (out_data.last_byte !== want.last_byte) begin
          report_mismatch($sformatf("last_byte %0b, predicted %0b (byte %02h)",
                                    out_data.last_byte, want.last_byte, want.tx_byte));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, all counts including zero and oversize, reset id
    queue_request(16'h0000, 32'h0000_0000, 3'd1);
    queue_request(16'hFFFF, 32'hFFFF_FFFF, 3'd4);
    queue_request(16'h0001, 32'h0000_0001, 3'd1);
    queue_request(16'h8000, 32'h8000_0000, 3'd4);
    queue_request(16'h1234, 32'h89AB_CDEF, 3'd2);
    queue_request(16'hABCD, 32'h1234_5678, 3'd3);
    queue_request(16'h00FF, 32'hFF00_FF00, 3'd4);
    queue_request(16'hFF00, 32'h00FF_00FF, 3'd4);
    queue_request(16'h5555, 32'hAAAA_AAAA, 3'd4);
    queue_request(16'hAAAA, 32'h5555_5555, 3'd4);
    queue_request(16'h0040, 32'h0000_00C3, 3'd0);
    queue_request(16'h0074, 32'h0102_0304, 3'd5);
    queue_request(16'hFFFE, 32'hDEAD_BEEF, 3'd6);
    queue_request(16'h7FFF, 32'h7FFF_FFFF, 3'd7);
    queue_request(16'h0000, 32'hFFFF_FFFF, 3'd3);
    queue_request(16'hFFFF, 32'h0000_0000, 3'd2);

    write_servo_id(8'd0);
    send_idle_pct = 74;
    queue_request(16'h0084, 32'h0000_0200, 3'd4);
    queue_random(20);

    write_servo_id(8'd253);
    send_idle_pct = 0;
    recv_stall_pct = 74;
    queue_random(22);

    write_servo_id(8'd255);
    send_idle_pct = 24;
    recv_stall_pct = 24;
    queue_random(22);

    // receiver blocked while requests keep coming, so the input backs up
    write_servo_id(8'd254);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_seq++;
    queue_random(22);

    write_servo_id(8'($urandom_range(253)));
    queue_random(8);

    wait_drained();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && packet_byte_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
